@@ rtl/rfs_pkg.sv @@
// shared types, command codes and channel widening helpers for the rgb565 spi stream block
`default_nettype none
package rfs_pkg;

	localparam int SIZE_BITS = 13;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RESET = 13'd320;
	localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

	localparam logic [7:0] CMD_COL_SET = 8'h2A;
	localparam logic [7:0] CMD_ROW_SET = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

	// byte positions within one request, header first
	localparam int STEP_BITS = 4;
	localparam logic [STEP_BITS-1:0] STEP_COL_CMD = 4'd0;
	localparam logic [STEP_BITS-1:0] STEP_COL_Z0 = 4'd1;
	localparam logic [STEP_BITS-1:0] STEP_COL_Z1 = 4'd2;
	localparam logic [STEP_BITS-1:0] STEP_COL_HI = 4'd3;
	localparam logic [STEP_BITS-1:0] STEP_COL_LO = 4'd4;
	localparam logic [STEP_BITS-1:0] STEP_ROW_CMD = 4'd5;
	localparam logic [STEP_BITS-1:0] STEP_ROW_Z0 = 4'd6;
	localparam logic [STEP_BITS-1:0] STEP_ROW_Z1 = 4'd7;
	localparam logic [STEP_BITS-1:0] STEP_ROW_HI = 4'd8;
	localparam logic [STEP_BITS-1:0] STEP_ROW_LO = 4'd9;
	localparam logic [STEP_BITS-1:0] STEP_MEM_CMD = 4'd10;
	localparam logic [STEP_BITS-1:0] STEP_RED = 4'd11;
	localparam logic [STEP_BITS-1:0] STEP_GREEN = 4'd12;
	localparam logic [STEP_BITS-1:0] STEP_BLUE = 4'd13;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        start;
		logic        done;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] col_end;
		logic [15:0] row_end;
	} entry_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/rfs_front.sv @@
// front end: size registers, raster counters and pixel classification
`default_nettype none
module rfs_front #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [rfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [rfs_pkg::SIZE_BITS-1:0]       cfg_data,
	input  wire logic                                pixel_valid,
	input  wire logic [15:0]                         pixel_rgb565,
	input  wire logic                                push_ready,
	output logic                                     push_valid,
	output rfs_pkg::entry_t                          push_entry
);
	import rfs_pkg::*;

	localparam logic [16:0] LIM_W = 17'd1 << COORD_BITS;

	logic [SIZE_BITS-1:0]  frame_width_q;
	logic [SIZE_BITS-1:0]  frame_height_q;
	logic [COORD_BITS-1:0] column_count_q;
	logic [COORD_BITS-1:0] row_count_q;
	logic [COORD_BITS-1:0] col_end;
	logic [COORD_BITS-1:0] row_end;
	logic [16:0]           width_w;
	logic [16:0]           height_w;
	logic                  accept;
	logic                  col_wrap;
	logic                  row_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything beyond the counter range clamps to it
	always_comb begin
		width_w = {4'd0, frame_width_q};
		height_w = {4'd0, frame_height_q};
		if (width_w == 17'd0)
			col_end = '0;
		else if (width_w > LIM_W)
			col_end = '1;
		else
			col_end = COORD_BITS'(width_w - 17'd1);
		if (height_w == 17'd0)
			row_end = '0;
		else if (height_w > LIM_W)
			row_end = '1;
		else
			row_end = COORD_BITS'(height_w - 17'd1);
	end

	assign accept = pixel_valid && push_ready;
	assign col_wrap = column_count_q >= col_end;
	assign row_wrap = row_count_q >= row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				column_count_q <= '0;
				if (row_wrap)
					row_count_q <= '0;
				else
					row_count_q <= row_count_q + 1'b1;
			end else begin
				column_count_q <= column_count_q + 1'b1;
			end
		end
	end

	assign push_valid = pixel_valid;

	always_comb begin
		push_entry.start = (column_count_q == '0) && (row_count_q == '0);
		push_entry.done = col_wrap && row_wrap;
		push_entry.red = widen5(pixel_rgb565[15:11]);
		push_entry.green = widen6(pixel_rgb565[10:5]);
		push_entry.blue = widen5(pixel_rgb565[4:0]);
		push_entry.col_end = 16'(col_end);
		push_entry.row_end = 16'(row_end);
	end

endmodule
`default_nettype wire

@@ rtl/rfs_queue.sv @@
// short register queue between front and back ends
`default_nettype none
module rfs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire rfs_pkg::entry_t  in_entry,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rfs_pkg::entry_t       out_entry
);
	import rfs_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	entry_t          slot_q [QDEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign in_ready = count_q != CW'(QDEPTH);
	assign out_valid = count_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count beyond depth");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue pop lost");
`endif

endmodule
`default_nettype wire

@@ rtl/rfs_back.sv @@
// back end: byte sequencer and output register for the serial link
`default_nettype none
module rfs_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire rfs_pkg::entry_t  q_entry,
	output logic                  spi_valid,
	input  wire logic             spi_stall,
	output logic [7:0]            spi_byte,
	output logic                  is_data,
	output logic                  frame_done,
	output logic                  run_last
);
	import rfs_pkg::*;

	entry_t                cur_q;
	logic                  busy_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  valid_q;
	logic [7:0]            byte_q;
	logic                  is_data_q;
	logic                  done_q;
	logic                  last_q;
	logic                  adv;
	logic                  last_step;
	logic                  take;
	logic [7:0]            byte_c;
	logic                  cmd_c;

	assign adv = !valid_q || !spi_stall;
	assign last_step = busy_q && (step_q == STEP_BLUE);
	assign take = q_valid && (!busy_q || (adv && last_step));
	assign q_ready = take;

	always_comb begin
		cmd_c = 1'b0;
		case (step_q)
			STEP_COL_CMD: begin
				byte_c = CMD_COL_SET;
				cmd_c = 1'b1;
			end
			STEP_COL_Z0, STEP_COL_Z1, STEP_ROW_Z0, STEP_ROW_Z1: byte_c = 8'h00;
			STEP_COL_HI: byte_c = cur_q.col_end[15:8];
			STEP_COL_LO: byte_c = cur_q.col_end[7:0];
			STEP_ROW_CMD: begin
				byte_c = CMD_ROW_SET;
				cmd_c = 1'b1;
			end
			STEP_ROW_HI: byte_c = cur_q.row_end[15:8];
			STEP_ROW_LO: byte_c = cur_q.row_end[7:0];
			STEP_MEM_CMD: begin
				byte_c = CMD_MEM_WRITE;
				cmd_c = 1'b1;
			end
			STEP_RED: byte_c = cur_q.red;
			STEP_GREEN: byte_c = cur_q.green;
			STEP_BLUE: byte_c = cur_q.blue;
			default: byte_c = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= q_entry;
		if (adv) begin
			byte_q <= byte_c;
			is_data_q <= !cmd_c;
			done_q <= last_step && cur_q.done;
			last_q <= last_step;
		end
	end

	// a new request is loaded when idle, or while the blue byte of the current one goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_COL_CMD;
			valid_q <= 1'b0;
		end else begin
			if (adv)
				valid_q <= busy_q;
			if (take) begin
				busy_q <= 1'b1;
				step_q <= q_entry.start ? STEP_COL_CMD : STEP_RED;
			end else if (adv && last_step) begin
				busy_q <= 1'b0;
			end else if (adv && busy_q) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign spi_valid = valid_q;
	assign spi_byte = byte_q;
	assign is_data = is_data_q;
	assign frame_done = done_q;
	assign run_last = last_q;

`ifndef SYNTHESIS
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && done_q |-> last_q && is_data_q)
		else $error("frame end flagged off a pixel's final byte");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_BLUE)
		else $error("sequencer step out of range");
	a_header_only_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && step_q < STEP_RED |-> cur_q.start)
		else $error("header bytes for a pixel that does not start a frame");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && spi_stall |=> valid_q && $stable(byte_q))
		else $error("output changed under stall");
`endif

endmodule
`default_nettype wire

@@ rtl/rgb565_frame_to_spi_display_stream.sv @@
// rgb565 pixel stream to display controller spi byte stream, top level
// Usage: pixels enter in raster order on pixel_valid/pixel_stall with pixel_rgb565.
// Bytes leave on spi_valid/spi_stall with spi_byte, is_data (0 for a command),
// frame_done (last byte of a frame, chip select may be released after it) and
// run_last (last byte caused by one pixel).
// The first pixel of a frame produces the 11-byte window header (column set,
// row set, memory write) and then its three colour bytes; every other pixel
// produces three bytes. Channels are widened by bit replication.
// Throughput: one byte per cycle on the output while spi_stall is low, set by the
// back-end byte sequencer; a pixel gives three bytes, a frame's first pixel fourteen.
// A taken pixel passes the queue slot, the sequencer request and the output register.
// A two-entry queue sits between the pixel side and the byte sequencer, so the
// pixel side keeps accepting while output bytes wait.
// Sizes are written on cfg_valid/cfg_ready (index 0 width, 1 height), by the user
// only while idle; the block does not enforce it. cfg_ready is always high.
// Reset: width 320, height 480, raster position at the frame start, no bytes
// pending. A stall on the output holds the current byte; pixel_stall rises once
// the queue is full.
`default_nettype none
module rgb565_frame_to_spi_display_stream #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [rfs_pkg::SIZE_BITS-1:0]       cfg_data,
	input  wire logic                                pixel_valid,
	output logic                                     pixel_stall,
	input  wire logic [15:0]                         pixel_rgb565,
	output logic                                     spi_valid,
	input  wire logic                                spi_stall,
	output logic [7:0]                               spi_byte,
	output logic                                     is_data,
	output logic                                     frame_done,
	output logic                                     run_last
);
	import rfs_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	assign cfg_ready = 1'b1;
	assign pixel_stall = !push_ready;

	rfs_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_rgb565(pixel_rgb565),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_entry(push_entry)
	);

	rfs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(push_valid),
		.in_ready(push_ready),
		.in_entry(push_entry),
		.out_valid(pop_valid),
		.out_ready(pop_ready),
		.out_entry(pop_entry)
	);

	rfs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_ready(pop_ready),
		.q_entry(pop_entry),
		.spi_valid(spi_valid),
		.spi_stall(spi_stall),
		.spi_byte(spi_byte),
		.is_data(is_data),
		.frame_done(frame_done),
		.run_last(run_last)
	);

endmodule
`default_nettype wire
